// File: rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Types and constants shared by the task scheduler modules.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned NumSlotsDefault = 8;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    CMD_ADD      = 3'd0,
    CMD_DELETE   = 3'd1,
    CMD_ENABLE   = 3'd2,
    CMD_DISABLE  = 3'd3,
    CMD_ADDDELAY = 3'd4,
    CMD_TICK     = 3'd5,
    CMD_DISPATCH = 3'd6,
    CMD_NOP      = 3'd7
  } cmd_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  slot;
    logic [7:0]  task_ident;
    logic [31:0] ticks;
    logic [31:0] period_ticks;
    logic        coop_mode;
    logic        enable_flag;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] run_slot;
    logic [7:0] run_ident;
    logic       table_full;
    logic       last;
  } out_word_t;

  // classified command handed from front to back
  typedef struct packed {
    cmd_t        op;
    logic        in_range;
    logic [2:0]  slot;
    logic [7:0]  task_ident;
    logic [31:0] ticks;
    logic [31:0] period_ticks;
    logic        coop_mode;
    logic        enable_flag;
  } job_t;

endpackage

// File: rtl/tts_front.sv
// ----------------------------------------------------------------------------
// tts_front
// Accepts command words, decodes them and queues them for the back end.
// ----------------------------------------------------------------------------
module tts_front #(
  parameter int unsigned NUM_SLOTS = tts_pkg::NumSlotsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  output logic             stall,
  input  tts_pkg::in_word_t data,
  output logic             job_valid,
  input  logic             job_take,
  output tts_pkg::job_t    job
);

  localparam int unsigned Depth = tts_pkg::QueueDepth;

  tts_pkg::job_t q [Depth];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  tts_pkg::job_t decoded;
  logic          push;
  logic          pop;

  always_comb begin
    decoded.op           = tts_pkg::cmd_t'(data.cmd);
    decoded.in_range     = ({3'd0, data.slot} < 6'(NUM_SLOTS));
    decoded.slot         = data.slot;
    decoded.task_ident   = data.task_ident;
    decoded.ticks        = data.ticks;
    decoded.period_ticks = data.period_ticks;
    decoded.coop_mode    = data.coop_mode;
    decoded.enable_flag  = data.enable_flag;
  end

  assign stall     = (count == 2'(Depth));
  assign push      = valid && !stall;
  assign job_valid = (count != 2'd0);
  assign pop       = job_valid && job_take;
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= decoded;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/tts_back.sv
// ----------------------------------------------------------------------------
// tts_back
// Slot table and sequencer: executes commands, walks slots one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module tts_back #(
  parameter int unsigned NUM_SLOTS = tts_pkg::NumSlotsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_take,
  input  tts_pkg::job_t     job,
  output logic              valid,
  input  logic              stall,
  output tts_pkg::out_word_t data
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

  state_t              state;
  tts_pkg::job_t       cur;
  logic [IdxW-1:0]     idx;
  logic [CntW-1:0]     slots_used;
  logic                slot_valid   [NUM_SLOTS];
  logic [7:0]          slot_ident   [NUM_SLOTS];
  logic [31:0]         slot_delay   [NUM_SLOTS];
  logic [31:0]         slot_period  [NUM_SLOTS];
  logic [7:0]          slot_pending [NUM_SLOTS];
  logic                slot_coop    [NUM_SLOTS];
  logic                slot_enabled [NUM_SLOTS];
  logic [IdxW-1:0]     sidx;
  logic [IdxW-1:0]     uidx;
  logic                out_free;
  logic                walk_emit;

  assign sidx     = IdxW'(cur.slot);
  assign uidx     = slots_used[IdxW-1:0];
  assign out_free = !valid || !stall;
  assign job_take = (state == S_IDLE);

  always_comb begin
    walk_emit = 1'b0;
    if (cur.op == tts_pkg::CMD_TICK) begin
      walk_emit = slot_enabled[idx] && slot_delay[idx] == 32'd0 && !slot_coop[idx]
                  && slot_valid[idx];
    end else begin
      walk_emit = slot_coop[idx] && slot_pending[idx] != 8'd0 && slot_valid[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid      <= 1'b0;
      idx        <= '0;
      slots_used <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_valid[i]   <= 1'b0;
        slot_ident[i]   <= 8'd0;
        slot_delay[i]   <= 32'd0;
        slot_period[i]  <= 32'd0;
        slot_pending[i] <= 8'd0;
        slot_coop[i]    <= 1'b1;
        slot_enabled[i] <= 1'b0;
      end
    end else begin
      if (valid && !stall) valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            idx   <= '0;
            state <= (job.op == tts_pkg::CMD_TICK || job.op == tts_pkg::CMD_DISPATCH)
                     ? S_WALK : S_DONE;
          end
        end
        S_WALK: begin
          if (out_free) begin
            if (walk_emit) begin
              valid          <= 1'b1;
              data.kind      <= 1'b0;
              data.run_slot  <= 3'(idx);
              data.run_ident <= slot_ident[idx];
              data.table_full <= 1'b0;
              data.last      <= 1'b0;
            end
            if (cur.op == tts_pkg::CMD_TICK) begin
              if (slot_enabled[idx]) begin
                if (slot_delay[idx] == 32'd0) begin
                  if (slot_coop[idx] && slot_pending[idx] != 8'hFF) begin
                    slot_pending[idx] <= slot_pending[idx] + 8'd1;
                  end
                  if (slot_period[idx] != 32'd0) begin
                    slot_delay[idx] <= slot_period[idx] - 32'd1;
                  end
                end else begin
                  slot_delay[idx] <= slot_delay[idx] - 32'd1;
                end
              end
            end else begin
              if (slot_coop[idx] && slot_pending[idx] != 8'd0) begin
                slot_pending[idx] <= slot_pending[idx] - 8'd1;
              end
              if (slot_period[idx] == 32'd0) slot_valid[idx] <= 1'b0;
            end
            if ({1'b0, idx} == (IdxW + 1)'(NUM_SLOTS - 1)) begin
              state <= S_DONE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            valid           <= 1'b1;
            data.kind       <= 1'b1;
            data.run_slot   <= 3'd0;
            data.run_ident  <= 8'd0;
            data.table_full <= 1'b0;
            data.last       <= 1'b1;
            state           <= S_IDLE;
            case (cur.op)
              tts_pkg::CMD_ADD: begin
                if (slots_used < CntW'(NUM_SLOTS)) begin
                  slot_valid[uidx]   <= 1'b1;
                  slot_ident[uidx]   <= cur.task_ident;
                  slot_delay[uidx]   <= cur.ticks;
                  slot_period[uidx]  <= cur.period_ticks;
                  slot_pending[uidx] <= 8'd0;
                  slot_coop[uidx]    <= cur.coop_mode;
                  slot_enabled[uidx] <= cur.enable_flag;
                  slots_used         <= slots_used + 1'b1;
                  data.run_slot      <= 3'(uidx);
                end else begin
                  data.table_full <= 1'b1;
                  data.run_slot   <= 3'(NUM_SLOTS - 1);
                end
              end
              tts_pkg::CMD_DELETE: begin
                if (cur.in_range) begin
                  slot_valid[sidx]   <= 1'b0;
                  slot_delay[sidx]   <= 32'd0;
                  slot_period[sidx]  <= 32'd0;
                  slot_pending[sidx] <= 8'd0;
                  slot_enabled[sidx] <= 1'b0;
                end
              end
              tts_pkg::CMD_ENABLE: begin
                if (cur.in_range) slot_enabled[sidx] <= 1'b1;
              end
              tts_pkg::CMD_DISABLE: begin
                if (cur.in_range) begin
                  slot_enabled[sidx] <= 1'b0;
                  slot_delay[sidx]   <= 32'd0;
                end
              end
              tts_pkg::CMD_ADDDELAY: begin
                if (cur.in_range) slot_delay[sidx] <= slot_delay[sidx] + cur.ticks;
              end
              default: begin
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/time_triggered_task_scheduler_top.sv
// Commands other than tick/dispatch pass through the back end's idle and done states
// and then emit a done word. Tick and dispatch walk the slot table one slot per cycle
// while the output is not stalled, then emit a done word. One command executes
// at a time; a two-word queue lets the next commands be accepted meanwhile.
// Synchronous reset clears the slot table and allocation index.
// ----------------------------------------------------------------------------
// time_triggered_task_scheduler_top
// Task slot scheduler: command front end, queue, slot table back end.
// ----------------------------------------------------------------------------
module time_triggered_task_scheduler_top #(
  parameter int unsigned NUM_SLOTS = tts_pkg::NumSlotsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tts_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tts_pkg::out_word_t out_data
);

  logic          job_valid;
  logic          job_take;
  tts_pkg::job_t job;

  tts_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
    .clk, .rst, .valid(in_valid), .stall(in_stall), .data(in_data),
    .job_valid, .job_take, .job
  );

  tts_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk, .rst, .job_valid, .job_take, .job,
    .valid(out_valid), .stall(out_stall), .data(out_data)
  );

endmodule

// File: rtl/tts_checker.sv
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks for the task scheduler.
// ----------------------------------------------------------------------------
module tts_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input tts_pkg::out_word_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled word changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("stalled input word dropped");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.last == out_data.kind)
    else $error("last does not match kind");

  a_full_add: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> !out_data.table_full)
    else $error("table_full on run word");

  a_reset_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind time_triggered_task_scheduler_top tts_checker u_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
